// ----- hw/rtl/cpf_pkg.sv -----
package cpf_pkg;

	localparam int POINTS_DEF     = 8;
	localparam int COORD_BITS_DEF = 16;

	localparam logic [1:0] CMD_LOAD    = 2'd0;
	localparam logic [1:0] CMD_COMPUTE = 2'd1;
	localparam logic [1:0] CMD_CLEAR   = 2'd2;

	localparam logic [1:0] KIND_ACK     = 2'd0;
	localparam logic [1:0] KIND_SUMMARY = 2'd1;
	localparam logic [1:0] KIND_PAIR    = 2'd2;
	localparam logic [1:0] KIND_ERROR   = 2'd3;

	typedef struct packed {
		logic        [1:0]  cmd;
		logic signed [15:0] x_coord;
		logic signed [15:0] y_coord;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [32:0] min_sq_dist;
		logic [4:0]  pair_count;
		logic [2:0]  first_index;
		logic [2:0]  second_index;
		logic [3:0]  point_count;
		logic        overflow;
		logic        last;
	} res_t;

	typedef struct packed {
		logic       issue;
		logic       pass_tie;
		logic       load;
		logic       clear;
		logic       start;
		logic       emit;
		logic [1:0] kind;
		logic       last;
		logic       ovf;
	} ctl_t;

	typedef struct packed {
		logic busy;
		logic tie_hit;
		logic last_tie;
		logic out_free;
		logic full;
	} sts_t;

endpackage

// ----- hw/rtl/cpf_datapath.sv -----
module cpf_datapath #(
	parameter int POINTS     = cpf_pkg::POINTS_DEF,
	parameter int COORD_BITS = cpf_pkg::COORD_BITS_DEF,
	localparam int IDX_W     = $clog2(POINTS),
	localparam int CNT_W     = $clog2(POINTS + 1),
	localparam int NPAIRS    = POINTS * (POINTS - 1) / 2,
	localparam int PAIR_W    = (NPAIRS > 1) ? $clog2(NPAIRS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cpf_pkg::ctl_t       ctl,
	input  cpf_pkg::item_t      item,
	input  logic [IDX_W-1:0]    rd_i,
	input  logic [IDX_W-1:0]    rd_j,
	input  logic [PAIR_W-1:0]   pair,
	output logic [CNT_W-1:0]    count,
	output cpf_pkg::sts_t       sts,
	input  logic                res_stall,
	output logic                res_valid,
	output cpf_pkg::res_t       res
);

	localparam int CB     = COORD_BITS;
	localparam int DIST_W = 2 * CB + 2;
	localparam int TIE_W  = $clog2(NPAIRS + 1);

	logic [2*CB-1:0]   mem_q [POINTS];
	logic [CNT_W-1:0]  count_q, count_d;
	logic [DIST_W-1:0] best_q;
	logic [TIE_W-1:0]  ties_q, emit_q;
	logic [NPAIRS-1:0] mask_q;
	logic              full;

	logic              v_s1, v_s2, v_s3, v_s4;
	logic              tie_s1, tie_s2, tie_s3, tie_s4;
	logic [PAIR_W-1:0] p_s1, p_s2, p_s3, p_s4;
	logic [2*CB-1:0]   ra_s1, rb_s1;
	logic [CB:0]       dx_s2, dy_s2;
	logic [DIST_W-1:0] sx_s3, sy_s3;
	logic [DIST_W-1:0] d_s4;

	logic signed [31:0] xw, yw;
	logic signed [CB:0] ddx, ddy;
	logic [31:0]        ties_w;
	logic               res_valid_q;
	cpf_pkg::res_t      res_q, res_d;

	assign xw   = 32'(item.x_coord);
	assign yw   = 32'(item.y_coord);
	assign full = (count_q == CNT_W'(POINTS));

	always_comb begin
		count_d = count_q;
		if (ctl.clear) begin
			count_d = '0;
		end else if (ctl.load && !full) begin
			count_d = CNT_W'(count_q + 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load && !full) begin
			mem_q[count_q[IDX_W-1:0]] <= {xw[CB-1:0], yw[CB-1:0]};
		end
		ra_s1 <= mem_q[rd_i];
		rb_s1 <= mem_q[rd_j];
	end

	always_comb begin
		ddx = {ra_s1[2*CB-1], ra_s1[2*CB-1:CB]} - {rb_s1[2*CB-1], rb_s1[2*CB-1:CB]};
		ddy = {ra_s1[CB-1], ra_s1[CB-1:0]} - {rb_s1[CB-1], rb_s1[CB-1:0]};
	end

	always_ff @(posedge clk) begin
		p_s1   <= pair;
		tie_s1 <= ctl.pass_tie;
		dx_s2  <= ddx[CB] ? $unsigned(-ddx) : $unsigned(ddx);
		dy_s2  <= ddy[CB] ? $unsigned(-ddy) : $unsigned(ddy);
		p_s2   <= p_s1;
		tie_s2 <= tie_s1;
		sx_s3  <= dx_s2 * dx_s2;
		sy_s3  <= dy_s2 * dy_s2;
		p_s3   <= p_s2;
		tie_s3 <= tie_s2;
		d_s4   <= sx_s3 + sy_s3;
		p_s4   <= p_s3;
		tie_s4 <= tie_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			count_q <= '0;
			best_q  <= '0;
			ties_q  <= '0;
			emit_q  <= '0;
			mask_q  <= '0;
		end else begin
			v_s1    <= ctl.issue;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			count_q <= count_d;
			if (ctl.start) begin
				ties_q <= '0;
				emit_q <= '0;
				mask_q <= '0;
			end else if (v_s4) begin
				if (!tie_s4) begin
					if (p_s4 == '0 || d_s4 < best_q) begin
						best_q <= d_s4;
					end
				end else if (d_s4 == best_q) begin
					ties_q       <= TIE_W'(ties_q + 1'b1);
					mask_q[p_s4] <= 1'b1;
				end
			end
			if (ctl.emit && ctl.kind == cpf_pkg::KIND_PAIR) begin
				emit_q <= TIE_W'(emit_q + 1'b1);
			end
		end
	end

	assign ties_w = 32'(ties_q);

	always_comb begin
		res_d              = '0;
		res_d.kind         = ctl.kind;
		res_d.point_count  = 4'(count_d);
		res_d.overflow     = ctl.ovf;
		res_d.last         = ctl.last;
		if (ctl.kind == cpf_pkg::KIND_SUMMARY && count_q != '0) begin
			res_d.min_sq_dist = 33'(best_q);
			res_d.pair_count  = (ties_w > 32'd31) ? 5'd31 : 5'(ties_q);
		end
		if (ctl.kind == cpf_pkg::KIND_PAIR) begin
			res_d.first_index  = 3'(rd_i);
			res_d.second_index = 3'(rd_j);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			res_q <= res_d;
		end
	end

	assign res_valid    = res_valid_q;
	assign res          = res_q;
	assign count        = count_q;
	assign sts.busy     = v_s1 | v_s2 | v_s3 | v_s4;
	assign sts.tie_hit  = mask_q[pair];
	assign sts.last_tie = (TIE_W'(emit_q + 1'b1) == ties_q);
	assign sts.out_free = !res_valid_q || !res_stall;
	assign sts.full     = full;

endmodule

// ----- hw/rtl/cpf_controller.sv -----
module cpf_controller #(
	parameter int POINTS  = cpf_pkg::POINTS_DEF,
	localparam int IDX_W  = $clog2(POINTS),
	localparam int CNT_W  = $clog2(POINTS + 1),
	localparam int NPAIRS = POINTS * (POINTS - 1) / 2,
	localparam int PAIR_W = (NPAIRS > 1) ? $clog2(NPAIRS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [1:0]        item_cmd,
	input  logic [CNT_W-1:0]  count,
	input  cpf_pkg::sts_t     sts,
	output cpf_pkg::ctl_t     ctl,
	output logic [IDX_W-1:0]  rd_i,
	output logic [IDX_W-1:0]  rd_j,
	output logic [PAIR_W-1:0] pair
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_MIN      = 3'd1;
	localparam logic [2:0] ST_MIN_WAIT = 3'd2;
	localparam logic [2:0] ST_TIE      = 3'd3;
	localparam logic [2:0] ST_TIE_WAIT = 3'd4;
	localparam logic [2:0] ST_SUM      = 3'd5;
	localparam logic [2:0] ST_EMIT     = 3'd6;

	logic [2:0]        state_q, state_d;
	logic [IDX_W-1:0]  i_q, j_q;
	logic [PAIR_W-1:0] p_q;
	logic              ctr_clr, ctr_adv;
	logic              j_end, last_pair, accept;

	assign j_end     = (CNT_W'(j_q) == CNT_W'(count - 1'b1));
	assign last_pair = j_end && (CNT_W'(i_q) == CNT_W'(count - 2'd2));
	assign item_stall = (state_q != ST_IDLE) || !sts.out_free;
	assign accept    = item_valid && !item_stall;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		ctr_clr = 1'b0;
		ctr_adv = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ctl.emit = 1'b1;
					ctl.last = 1'b1;
					case (item_cmd)
						cpf_pkg::CMD_LOAD: begin
							ctl.load = 1'b1;
							ctl.kind = cpf_pkg::KIND_ACK;
							ctl.ovf  = sts.full;
						end
						cpf_pkg::CMD_CLEAR: begin
							ctl.clear = 1'b1;
							ctl.kind  = cpf_pkg::KIND_ACK;
						end
						cpf_pkg::CMD_COMPUTE: begin
							if (count == '0) begin
								ctl.kind = cpf_pkg::KIND_SUMMARY;
							end else if (count == CNT_W'(1)) begin
								ctl.kind = cpf_pkg::KIND_ERROR;
							end else begin
								ctl.emit  = 1'b0;
								ctl.last  = 1'b0;
								ctl.start = 1'b1;
								ctr_clr   = 1'b1;
								state_d   = ST_MIN;
							end
						end
						default: begin
							ctl.kind = cpf_pkg::KIND_ERROR;
						end
					endcase
				end
			end
			ST_MIN, ST_TIE: begin
				ctl.issue    = 1'b1;
				ctl.pass_tie = (state_q == ST_TIE);
				ctr_adv      = 1'b1;
				if (last_pair) begin
					state_d = (state_q == ST_TIE) ? ST_TIE_WAIT : ST_MIN_WAIT;
				end
			end
			ST_MIN_WAIT: begin
				if (!sts.busy) begin
					ctr_clr = 1'b1;
					state_d = ST_TIE;
				end
			end
			ST_TIE_WAIT: begin
				if (!sts.busy) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				if (sts.out_free) begin
					ctl.emit = 1'b1;
					ctl.kind = cpf_pkg::KIND_SUMMARY;
					ctr_clr  = 1'b1;
					state_d  = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.tie_hit) begin
					if (sts.out_free) begin
						ctl.emit = 1'b1;
						ctl.kind = cpf_pkg::KIND_PAIR;
						ctl.last = sts.last_tie;
						ctr_adv  = 1'b1;
						if (sts.last_tie || last_pair) begin
							state_d = ST_IDLE;
						end
					end
				end else begin
					ctr_adv = 1'b1;
					if (last_pair) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			p_q     <= '0;
		end else begin
			state_q <= state_d;
			if (ctr_clr) begin
				i_q <= '0;
				j_q <= IDX_W'(1);
				p_q <= '0;
			end else if (ctr_adv) begin
				p_q <= PAIR_W'(p_q + 1'b1);
				if (j_end) begin
					i_q <= IDX_W'(i_q + 1'b1);
					j_q <= IDX_W'(i_q + 2'd2);
				end else begin
					j_q <= IDX_W'(j_q + 1'b1);
				end
			end
		end
	end

	assign rd_i = i_q;
	assign rd_j = j_q;
	assign pair = p_q;

endmodule

// ----- hw/rtl/closest_pair_finder.sv -----
// Brute-force closest pair finder over a small point store.
// item channel (item_valid/item_stall/item): one command per transaction.
//   load stores a point at the next index, clear empties the store,
//   compute scans every pair i < j by squared distance.
// res channel (res_valid/res_stall/res): results from a single output register.
//   load, clear, unused command, compute on zero or one point: one result,
//   valid the cycle after the command is taken.
//   compute on n >= 2 points, P = n*(n-1)/2 pairs: a minimum pass and a
//   tie-count pass, one pair per cycle each through a 4-stage distance
//   pipeline (store read, difference, square, sum), each pass drained
//   before moving on, then the summary and a walk over the pairs up to the
//   last tied one at one pair per cycle unless a tied pair waits for the
//   output register, emitting every tied pair.
// A new command is taken only when the sequence is done and the output
// register is free or being drained in the same cycle.
// res_stall holds the output register and freezes the sequencer at the next
// result; the item channel stalls meanwhile.
// Reset empties the store and returns to idle; stored coordinates are not reset.
module closest_pair_finder #(
	parameter int POINTS     = cpf_pkg::POINTS_DEF,
	parameter int COORD_BITS = cpf_pkg::COORD_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  cpf_pkg::item_t item,
	output logic           res_valid,
	input  logic           res_stall,
	output cpf_pkg::res_t  res
);

	localparam int IDX_W  = $clog2(POINTS);
	localparam int CNT_W  = $clog2(POINTS + 1);
	localparam int NPAIRS = POINTS * (POINTS - 1) / 2;
	localparam int PAIR_W = (NPAIRS > 1) ? $clog2(NPAIRS) : 1;

	cpf_pkg::ctl_t     ctl;
	cpf_pkg::sts_t     sts;
	logic [IDX_W-1:0]  rd_i, rd_j;
	logic [PAIR_W-1:0] pair;
	logic [CNT_W-1:0]  count;

	cpf_controller #(
		.POINTS (POINTS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item_cmd   (item.cmd),
		.count      (count),
		.sts        (sts),
		.ctl        (ctl),
		.rd_i       (rd_i),
		.rd_j       (rd_j),
		.pair       (pair)
	);

	cpf_datapath #(
		.POINTS     (POINTS),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.item      (item),
		.rd_i      (rd_i),
		.rd_j      (rd_j),
		.pair      (pair),
		.count     (count),
		.sts       (sts),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res       (res)
	);

endmodule

// ----- hw/rtl/cpf_checker.sv -----
module cpf_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           item_valid,
	input logic           item_stall,
	input cpf_pkg::item_t item,
	input logic           res_valid,
	input logic           res_stall,
	input cpf_pkg::res_t  res
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result transaction dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res))
		else $error("result payload changed while stalled");

	a_load_ack: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.cmd == cpf_pkg::CMD_LOAD |=>
		res_valid && res.kind == cpf_pkg::KIND_ACK && res.last)
		else $error("load not answered by an acknowledge");

	a_clear_ack: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.cmd == cpf_pkg::CMD_CLEAR |=>
		res_valid && res.kind == cpf_pkg::KIND_ACK && res.point_count == 4'd0
		&& !res.overflow)
		else $error("clear not answered by an empty acknowledge");

endmodule

bind closest_pair_finder cpf_checker u_cpf_checker (.*);

// ----- verif/closest_pair_finder_tb.sv -----
module closest_pair_finder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cpf_pkg::*;

	localparam int         NPTS        = POINTS_DEF;
	localparam logic [1:0] CMD_UNUSED  = 2'd3;
	localparam int         HOLD_AT     = 70;
	localparam int         HOLD_CYCLES = 300;
	localparam int         LIMIT       = 1000000;

	typedef struct {
		item_t it;
		bit    pause;
	} stim_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  item_valid = 1'b0;
	logic  item_stall;
	item_t item = '0;
	logic  res_valid;
	logic  res_stall = 1'b0;
	res_t  res;

	stim_t stim_q[$];
	res_t  expected_res_q[$];

	logic signed [15:0] pt_x [NPTS];
	logic signed [15:0] pt_y [NPTS];
	int                 stored_cnt = 0;

	int mismatch_cnt = 0;
	int accepted_cnt = 0;
	int cycle_cnt = 0;
	int send_gap = 0;
	int send_calm = 0;
	int stall_left = 0;
	int recv_calm = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	closest_pair_finder u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic longint pair_sq_dist(int i, int j);
		longint dx, dy;
		dx = longint'(pt_x[i]) - longint'(pt_x[j]);
		dy = longint'(pt_y[i]) - longint'(pt_y[j]);
		return dx * dx + dy * dy;
	endfunction

	function automatic void predict_closest_pairs(item_t it);
		res_t   r;
		longint best;
		int     ties;
		int     k;
		r = '0;
		r.last = 1'b1;
		case (it.cmd)
			CMD_LOAD: begin
				r.kind = KIND_ACK;
				if (stored_cnt < NPTS) begin
					pt_x[stored_cnt] = it.x_coord;
					pt_y[stored_cnt] = it.y_coord;
					stored_cnt++;
				end else begin
					r.overflow = 1'b1;
				end
				r.point_count = 4'(stored_cnt);
				expected_res_q.push_back(r);
			end
			CMD_CLEAR: begin
				stored_cnt = 0;
				r.kind = KIND_ACK;
				expected_res_q.push_back(r);
			end
			CMD_COMPUTE: begin
				r.point_count = 4'(stored_cnt);
				if (stored_cnt == 1) begin
					r.kind = KIND_ERROR;
					expected_res_q.push_back(r);
				end else begin
					best = 0;
					ties = 0;
					for (int i = 0; i < stored_cnt - 1; i++)
						for (int j = i + 1; j < stored_cnt; j++)
							if ((i == 0 && j == 1) || pair_sq_dist(i, j) < best)
								best = pair_sq_dist(i, j);
					for (int i = 0; i < stored_cnt - 1; i++)
						for (int j = i + 1; j < stored_cnt; j++)
							if (pair_sq_dist(i, j) == best)
								ties++;
					r.kind = KIND_SUMMARY;
					r.min_sq_dist = best[32:0];
					r.pair_count = 5'(ties);
					r.last = (ties == 0);
					expected_res_q.push_back(r);
					k = 0;
					for (int i = 0; i < stored_cnt - 1; i++)
						for (int j = i + 1; j < stored_cnt; j++)
							if (pair_sq_dist(i, j) == best) begin
								k++;
								r = '0;
								r.kind = KIND_PAIR;
								r.first_index = 3'(i);
								r.second_index = 3'(j);
								r.point_count = 4'(stored_cnt);
								r.last = (k == ties);
								expected_res_q.push_back(r);
							end
				end
			end
			default: begin
				r.kind = KIND_ERROR;
				r.point_count = 4'(stored_cnt);
				expected_res_q.push_back(r);
			end
		endcase
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("MISMATCH @%0t: %s got %0d expected %0d", $time, what, got, want);
		mismatch_cnt++;
	endtask

	task automatic add_item(logic [1:0] c, logic signed [15:0] xv, logic signed [15:0] yv);
		stim_t s;
		s.it.cmd = c;
		s.it.x_coord = xv;
		s.it.y_coord = yv;
		s.pause = 1'b0;
		stim_q.push_back(s);
	endtask

	task automatic add_pause();
		stim_t s;
		s.it = '0;
		s.pause = 1'b1;
		stim_q.push_back(s);
	endtask

	function automatic logic signed [15:0] pick_coord(int span);
		if (span == 0)
			return 16'($urandom_range(0, 65535));
		return 16'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	// driver: next valid/item worked out in locals, one NBA each per edge
	always @(posedge clk or negedge arst_n) begin : drive_items
		logic  nxt_valid;
		item_t nxt_item;
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
		end else begin
			nxt_valid = item_valid;
			nxt_item = item;
			if (item_valid && !item_stall) begin
				predict_closest_pairs(item);
				accepted_cnt <= accepted_cnt + 1;
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (stim_q.size() > 0) begin
					if (stim_q[0].pause) begin
						if (expected_res_q.size() == 0)
							stim_q.delete(0);
					end else begin
						nxt_item = stim_q[0].it;
						stim_q.delete(0);
						nxt_valid = 1'b1;
						send_gap = pick_gap(send_calm);
					end
				end
			end
			item_valid <= nxt_valid;
			item <= nxt_item;
		end
	end

	// receiver: random stalls plus one long hold-off
	always @(posedge clk or negedge arst_n) begin : stall_results
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			res_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			res_stall <= 1'b1;
		end else begin
			stall_left = pick_gap(recv_calm);
			if (stall_left > 0) begin
				stall_left--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_res_q.size() == 0) begin
				report_mismatch("unexpected transaction, kind", res.kind, 0);
			end else begin
				want = expected_res_q.pop_front();
				if (res.kind !== want.kind)
					report_mismatch("kind", res.kind, want.kind);
				if (res.min_sq_dist !== want.min_sq_dist)
					report_mismatch("min_sq_dist", res.min_sq_dist, want.min_sq_dist);
				if (res.pair_count !== want.pair_count)
					report_mismatch("pair_count", res.pair_count, want.pair_count);
				if (res.first_index !== want.first_index)
					report_mismatch("first_index", res.first_index, want.first_index);
				if (res.second_index !== want.second_index)
					report_mismatch("second_index", res.second_index, want.second_index);
				if (res.point_count !== want.point_count)
					report_mismatch("point_count", res.point_count, want.point_count);
				if (res.overflow !== want.overflow)
					report_mismatch("overflow", res.overflow, want.overflow);
				if (res.last !== want.last)
					report_mismatch("last", res.last, want.last);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int  n;
		int  r;
		int  span;
		int  rand_cnt;
		bit  paused;
		logic [1:0] c;

		// directed: empty, single point, unused cmd, extreme coords, full store, ties
		add_item(CMD_COMPUTE, 16'sd0, 16'sd0);
		add_item(CMD_LOAD, -16'sd32768, 16'sd32767);
		add_item(CMD_COMPUTE, 16'sd0, 16'sd0);
		add_item(CMD_UNUSED, 16'sh5a5a, -16'sd1);
		add_item(CMD_LOAD, 16'sd32767, -16'sd32768);
		add_item(CMD_COMPUTE, 16'sd0, 16'sd0);
		add_item(CMD_CLEAR, -16'sd1, -16'sd1);
		for (int i = 0; i < NPTS; i++)
			add_item(CMD_LOAD, -16'sd1, -16'sd1);
		add_item(CMD_LOAD, 16'sd0, 16'sd0);
		add_item(CMD_COMPUTE, 16'sd0, 16'sd0);
		add_item(CMD_CLEAR, 16'sd0, 16'sd0);
		add_item(CMD_LOAD, 16'sd0, 16'sd0);
		add_item(CMD_LOAD, 16'sd3, 16'sd0);
		add_item(CMD_LOAD, 16'sd0, 16'sd3);
		add_item(CMD_LOAD, 16'sd3, 16'sd3);
		add_item(CMD_COMPUTE, 16'sd0, 16'sd0);
		add_item(CMD_CLEAR, 16'sd0, 16'sd0);
		add_item(CMD_COMPUTE, 16'sd0, 16'sd0);
		add_pause();

		// random: mostly clear/load/compute sets, some noise
		rand_cnt = 0;
		paused = 1'b0;
		while (rand_cnt < 95) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				r = $urandom_range(0, 2);
				span = (r == 0) ? 0 : (r == 1) ? 2 : 50;
				n = $urandom_range(0, NPTS + 2);
				add_item(CMD_CLEAR, pick_coord(0), pick_coord(0));
				for (int i = 0; i < n; i++)
					add_item(CMD_LOAD, pick_coord(span), pick_coord(span));
				add_item(CMD_COMPUTE, pick_coord(0), pick_coord(0));
				rand_cnt += n + 2;
				if ($urandom_range(0, 3) == 0) begin
					add_item(CMD_COMPUTE, pick_coord(0), pick_coord(0));
					rand_cnt++;
				end
			end else begin
				c = 2'($urandom_range(0, 3));
				add_item(c, pick_coord(0), pick_coord(0));
				rand_cnt++;
			end
			if (!paused && rand_cnt > 50) begin
				add_pause();
				paused = 1'b1;
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		while (stim_q.size() > 0 || item_valid)
			@(posedge clk);
		while (expected_res_q.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
